/* design/lzwc_pkg.sv */
// shared types and constants for the lzw byte compressor
`timescale 1ns / 1ps

package lzwc_pkg;

	// single-byte codes occupy 0..255, dictionary codes start here
	localparam int unsigned LITERALS = 256;

	// width of the code field on the result channel
	localparam int unsigned CODE_OUT_W = 12;

	// message generation tag kept in each hash slot
	localparam int unsigned EPOCH_W = 8;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_CHECK,
		ST_FINISH
	} state_t;

endpackage

/* design/lzw_byte_compressor_unit.sv */
// lzw byte compressor: hashed dictionary in one memory under a small sequencer
`timescale 1ns / 1ps

// channel   | direction | handshake               | word
// ----------+-----------+-------------------------+---------------------------
// byte      | in        | byte_valid / byte_ready | data_byte, last_byte
// code      | out       | code_valid / code_ready | code, end_of_message
//
// a byte that opens a message goes from idle to finish, else a probe and a check
// state per hash probe come between; the registered hash memory read sets this.
// after reset, and after every 255th message, a clearing pass over all
// 2 ** ($clog2(DICT_SIZE) + 1) hash slots (8192 at the default) holds byte_ready low.
// a stalled code channel holds the sequencer in the state that needs to emit.
// one output register decouples the code channel from the sequencer.

module lzw_byte_compressor_unit #(
	parameter int unsigned DICT_SIZE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        code_valid,
	input  logic        code_ready,
	output logic [11:0] code,
	output logic        end_of_message
);

	localparam int unsigned CODE_W    = $clog2(DICT_SIZE);
	localparam int unsigned NFC_W     = CODE_W + 1;
	localparam int unsigned TBL_AW    = CODE_W + 1;
	localparam int unsigned TBL_DEPTH = 1 << TBL_AW;
	localparam int unsigned KEY_W     = CODE_W + 8;
	localparam int unsigned SLOT_W    = lzwc_pkg::EPOCH_W + KEY_W + CODE_W;

	lzwc_pkg::state_t state_q, state_d;

	logic [7:0]                     byte_q;
	logic                           last_q;
	logic [CODE_W-1:0]              prefix_q;
	logic                           pvalid_q;
	logic [NFC_W-1:0]               nfc_q;
	logic [lzwc_pkg::EPOCH_W-1:0]   epoch_q;
	logic [TBL_AW-1:0]              probe_q;
	logic [TBL_AW-1:0]              clr_q;
	logic [SLOT_W-1:0]              rd_q;
	logic                           code_valid_q;
	logic [lzwc_pkg::CODE_OUT_W-1:0] code_q;
	logic                           eom_q;

	logic [SLOT_W-1:0] mem [TBL_DEPTH];

	logic [lzwc_pkg::EPOCH_W-1:0] rd_epoch;
	logic [KEY_W-1:0]             rd_key;
	logic [CODE_W-1:0]            rd_code;
	logic [KEY_W-1:0]             key;
	logic                         occupied;
	logic                         hit;
	logic                         out_free;
	logic                         room;
	logic                         clr_last;
	logic                         epoch_wrap;
	logic [TBL_AW-1:0]            hash;
	logic [CODE_W+lzwc_pkg::CODE_OUT_W-1:0] code_ext;

	// decoded controls
	logic take, mem_re, clr_we, ins_we, emit_miss, emit_end, grow, step;
	logic             mem_we;
	logic [TBL_AW-1:0] waddr;
	logic [SLOT_W-1:0] wdata;

	assign rd_epoch = rd_q[SLOT_W-1 -: lzwc_pkg::EPOCH_W];
	assign rd_key   = rd_q[CODE_W +: KEY_W];
	assign rd_code  = rd_q[CODE_W-1:0];
	assign key      = {prefix_q, byte_q};
	assign occupied = (rd_epoch == epoch_q);
	assign hit      = occupied && (rd_key == key);
	assign out_free = !code_valid_q || code_ready;
	assign room     = (nfc_q < NFC_W'(DICT_SIZE));
	assign clr_last = (clr_q == {TBL_AW{1'b1}});
	assign epoch_wrap = (epoch_q == {lzwc_pkg::EPOCH_W{1'b1}});
	// fold prefix and byte into a slot address
	assign hash     = TBL_AW'(prefix_q) ^ {data_byte, {(TBL_AW-8){1'b0}}};
	assign code_ext = {{lzwc_pkg::CODE_OUT_W{1'b0}}, prefix_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lzwc_pkg::ST_CLEAR: begin
				if (clr_last) state_d = lzwc_pkg::ST_IDLE;
			end
			lzwc_pkg::ST_IDLE: begin
				if (byte_valid) begin
					state_d = pvalid_q ? lzwc_pkg::ST_PROBE : lzwc_pkg::ST_FINISH;
				end
			end
			lzwc_pkg::ST_PROBE: begin
				state_d = lzwc_pkg::ST_CHECK;
			end
			lzwc_pkg::ST_CHECK: begin
				if (hit) state_d = lzwc_pkg::ST_FINISH;
				else if (occupied) state_d = lzwc_pkg::ST_PROBE;
				else if (out_free) state_d = lzwc_pkg::ST_FINISH;
			end
			lzwc_pkg::ST_FINISH: begin
				if (!last_q) state_d = lzwc_pkg::ST_IDLE;
				else if (out_free) begin
					state_d = epoch_wrap ? lzwc_pkg::ST_CLEAR : lzwc_pkg::ST_IDLE;
				end
			end
			default: state_d = lzwc_pkg::ST_CLEAR;
		endcase
	end

	// control decode
	always_comb begin
		byte_ready = 1'b0;
		take       = 1'b0;
		mem_re     = 1'b0;
		clr_we     = 1'b0;
		emit_miss  = 1'b0;
		ins_we     = 1'b0;
		emit_end   = 1'b0;
		grow       = 1'b0;
		step       = 1'b0;
		case (state_q)
			lzwc_pkg::ST_CLEAR: begin
				clr_we = 1'b1;
			end
			lzwc_pkg::ST_IDLE: begin
				byte_ready = 1'b1;
				take       = byte_valid;
			end
			lzwc_pkg::ST_PROBE: begin
				mem_re = 1'b1;
			end
			lzwc_pkg::ST_CHECK: begin
				grow      = hit;
				step      = occupied && !hit;
				emit_miss = !occupied && out_free;
				ins_we    = !occupied && out_free && room;
			end
			lzwc_pkg::ST_FINISH: begin
				emit_end = last_q && out_free;
			end
			default: begin
				clr_we = 1'b0;
			end
		endcase
	end

	assign mem_we = clr_we || ins_we;
	assign waddr  = clr_we ? clr_q : probe_q;
	assign wdata  = clr_we ? {SLOT_W{1'b0}} : {epoch_q, key, nfc_q[CODE_W-1:0]};

	// hash table memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (mem_re) rd_q <= mem[probe_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lzwc_pkg::ST_CLEAR;
			prefix_q     <= '0;
			pvalid_q     <= 1'b0;
			nfc_q        <= NFC_W'(lzwc_pkg::LITERALS);
			epoch_q      <= '0;
			clr_q        <= '0;
			code_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_we) begin
				clr_q <= clr_q + 1'b1;
				if (clr_last) epoch_q <= lzwc_pkg::EPOCH_W'(1);
			end
			if (take && !pvalid_q) begin
				prefix_q <= CODE_W'(data_byte);
				pvalid_q <= 1'b1;
			end
			if (grow) prefix_q <= rd_code;
			if (emit_miss) prefix_q <= CODE_W'(byte_q);
			if (ins_we) nfc_q <= nfc_q + 1'b1;
			if (emit_end) begin
				prefix_q <= '0;
				pvalid_q <= 1'b0;
				nfc_q    <= NFC_W'(lzwc_pkg::LITERALS);
				// a wrap goes through a clearing pass, which restarts the tag
				if (!epoch_wrap) epoch_q <= epoch_q + 1'b1;
			end
			if (emit_miss || emit_end) code_valid_q <= 1'b1;
			else if (code_ready) code_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			byte_q  <= data_byte;
			last_q  <= last_byte;
			probe_q <= hash;
		end else if (step) begin
			probe_q <= probe_q + 1'b1;
		end
		if (emit_miss || emit_end) begin
			code_q <= code_ext[lzwc_pkg::CODE_OUT_W-1:0];
			eom_q  <= emit_end;
		end
	end

	assign code_valid     = code_valid_q;
	assign code           = code_q;
	assign end_of_message = eom_q;

endmodule

/* design/lzwc_checker.sv */
// port-level checks for the lzw byte compressor, bound to the top level
`timescale 1ns / 1ps

module lzwc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        byte_valid,
	input logic        byte_ready,
	input logic        code_valid,
	input logic        code_ready,
	input logic [11:0] code,
	input logic        end_of_message
);

	// a stalled code word holds its value
	a_code_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && !code_ready |=> code_valid && $stable(code) && $stable(end_of_message))
		else $error("code word changed or dropped while stalled");

	// one byte at a time: busy right after a byte is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_ready |=> !byte_ready)
		else $error("byte taken while previous byte still in work");

	// a new code word only comes out of work on a byte, never from idle
	a_code_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(code_valid) |-> !$past(byte_ready))
		else $error("code word appeared while idle");

endmodule

bind lzw_byte_compressor_unit lzwc_checker u_lzwc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.byte_valid     (byte_valid),
	.byte_ready     (byte_ready),
	.code_valid     (code_valid),
	.code_ready     (code_ready),
	.code           (code),
	.end_of_message (end_of_message)
);
